@@ hw/rtl/clss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clss_pkg: shared types and codes for the sequence store
// Mode, status and cell operation codes plus the control word that the
// top level broadcasts along the cell chain.
// ----------------------------------------------------------------------------
package clss_pkg;

	localparam int DATA_W    = 32;
	localparam int MODE_W    = 3;
	localparam int STATUS_W  = 2;
	localparam int CNT_OUT_W = 6;
	// positions reach 63 at the largest supported capacity of 64
	localparam int POS_W     = 6;

	// input transaction modes
	localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INS_MID   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_INS_END   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DEL_MID   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_DEL_END   = 3'd5;
	localparam logic [MODE_W-1:0] MODE_TRAVERSE  = 3'd6;

	// result status
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// cell operations
	typedef logic [1:0] cell_op_t;
	localparam cell_op_t CELL_HOLD = 2'd0;
	localparam cell_op_t CELL_INS  = 2'd1;
	localparam cell_op_t CELL_DEL  = 2'd2;
	localparam cell_op_t CELL_ROT  = 2'd3;

	typedef struct packed {
		cell_op_t          op;
		logic [POS_W-1:0]  pos;    // insert/delete position, or tail for rotate
		logic [DATA_W-1:0] value;  // value written on insert
	} cell_ctl_t;

endpackage

@@ hw/rtl/circular_list_sequence_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_list_sequence_store: ordered store of signed 32-bit values
// Circular-list style sequence store built as a chain of shifting cells.
// Inserts and deletes at front, middle or end; traverse emits head to tail.
// ----------------------------------------------------------------------------
//
// Channel   Handshake                  Payload
// -------   -------------------------  ----------------------------------
// command   start & !busy              mode, value
// result    result_valid (one cycle)   status, value_out, last, count_out
//
// Insert, delete and the unused mode complete in the accepting edge: the whole
// chain shifts by one cell in that edge and the result shows the next cycle.
// A traverse of n entries holds busy high after the accepting edge while its
// n rotate steps run, and no new command is taken until busy falls. Each
// step rotates the first n cells one step and registers the head, so the
// n results follow one register behind; after n steps the order is back.
// Reset clears the entry count and the traverse control; cell contents are
// undefined until written and are never read beyond the count.
// The result side cannot stall; each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module circular_list_sequence_store #(
	parameter int CAPACITY = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [clss_pkg::MODE_W-1:0]           mode,
	input  logic signed [clss_pkg::DATA_W-1:0]    value,
	output logic                                  result_valid,
	output logic [clss_pkg::STATUS_W-1:0]         status,
	output logic signed [clss_pkg::DATA_W-1:0]    value_out,
	output logic                                  last,
	output logic [clss_pkg::CNT_OUT_W-1:0]        count_out
);

	// count needs to hold CAPACITY itself
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_CNT = CW'(1);

	// cell chain
	logic [clss_pkg::DATA_W-1:0] cell_data [CAPACITY];
	clss_pkg::cell_ctl_t         ctl;

	// control state
	logic [CW-1:0] count_q;
	logic          trav_q;    // traverse in progress
	logic [CW-1:0] rem_q;     // entries left to emit

	// result registers
	logic                          valid_q;
	logic [clss_pkg::STATUS_W-1:0] status_q;
	logic [clss_pkg::DATA_W-1:0]   value_out_q;
	logic                          last_q;
	logic [clss_pkg::CNT_OUT_W-1:0] count_out_q;

	logic                          accept;
	logic [CW-1:0]                 count_d;
	logic                          trav_start;
	logic                          res_load;
	logic [clss_pkg::STATUS_W-1:0] res_status;
	logic [CW-1:0]                 tail_pos;

	assign accept   = start & ~busy;
	assign tail_pos = count_q - ONE_CNT;

	// --------------------------------------------------------------------
	// command decode: one control word drives every cell
	// --------------------------------------------------------------------
	always_comb begin
		ctl.op     = clss_pkg::CELL_HOLD;
		ctl.pos    = '0;
		ctl.value  = value;
		count_d    = count_q;
		trav_start = 1'b0;
		res_load   = 1'b0;
		res_status = clss_pkg::ST_OK;

		if (trav_q) begin
			// rotate the live part of the chain, head wraps to the tail
			ctl.op  = clss_pkg::CELL_ROT;
			ctl.pos = clss_pkg::POS_W'(tail_pos);
		end else if (accept) begin
			res_load = 1'b1;
			case (mode)
				clss_pkg::MODE_INS_FRONT, clss_pkg::MODE_INS_MID,
				clss_pkg::MODE_INS_END: begin
					if (count_q >= CAP_CNT) begin
						res_status = clss_pkg::ST_FULL;
					end else begin
						ctl.op  = clss_pkg::CELL_INS;
						count_d = count_q + ONE_CNT;
						if (mode == clss_pkg::MODE_INS_FRONT) begin
							ctl.pos = '0;
						end else if (mode == clss_pkg::MODE_INS_END) begin
							ctl.pos = clss_pkg::POS_W'(count_q);
						end else if (count_q == ONE_CNT) begin
							// single entry: new value goes behind it
							ctl.pos = clss_pkg::POS_W'(1);
						end else begin
							ctl.pos = clss_pkg::POS_W'(count_q >> 1);
						end
					end
				end
				clss_pkg::MODE_DEL_FRONT, clss_pkg::MODE_DEL_MID,
				clss_pkg::MODE_DEL_END, clss_pkg::MODE_TRAVERSE: begin
					if (count_q == '0) begin
						res_status = clss_pkg::ST_EMPTY;
					end else if (mode == clss_pkg::MODE_TRAVERSE) begin
						res_load   = 1'b0;
						trav_start = 1'b1;
					end else begin
						ctl.op  = clss_pkg::CELL_DEL;
						count_d = count_q - ONE_CNT;
						if (mode == clss_pkg::MODE_DEL_FRONT) begin
							ctl.pos = '0;
						end else if (mode == clss_pkg::MODE_DEL_END) begin
							ctl.pos = clss_pkg::POS_W'(tail_pos);
						end else if (count_q == ONE_CNT) begin
							ctl.pos = '0;
						end else begin
							// (n+1)/2 without overflowing the count width
							ctl.pos = clss_pkg::POS_W'((count_q >> 1) +
								{{(CW-1){1'b0}}, count_q[0]});
						end
					end
				end
				default: begin
					// unused mode: plain ok, store untouched
					res_status = clss_pkg::ST_OK;
				end
			endcase
		end
	end

	// --------------------------------------------------------------------
	// cell chain
	// --------------------------------------------------------------------
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [clss_pkg::DATA_W-1:0] left_w;
		logic [clss_pkg::DATA_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end

		clss_cell #(
			.IDX(i)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.left  (left_w),
			.right (right_w),
			.head  (cell_data[0]),
			.data  (cell_data[i])
		);
	end

	// --------------------------------------------------------------------
	// control state
	// --------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			trav_q  <= 1'b0;
			rem_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			valid_q <= res_load | trav_q;
			if (trav_start) begin
				trav_q <= 1'b1;
				rem_q  <= count_q;
			end else if (trav_q) begin
				rem_q <= rem_q - ONE_CNT;
				if (rem_q == ONE_CNT) begin
					trav_q <= 1'b0;
				end
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (trav_q) begin
			status_q    <= clss_pkg::ST_OK;
			value_out_q <= cell_data[0];
			last_q      <= (rem_q == ONE_CNT);
			count_out_q <= clss_pkg::CNT_OUT_W'(count_q);
		end else if (res_load) begin
			status_q    <= res_status;
			value_out_q <= '0;
			last_q      <= 1'b1;
			count_out_q <= clss_pkg::CNT_OUT_W'(count_d);
		end
	end

	assign busy         = trav_q;
	assign result_valid = valid_q;
	assign status       = status_q;
	assign value_out    = value_out_q;
	assign last         = last_q;
	assign count_out    = count_out_q;

endmodule

@@ hw/rtl/clss_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clss_cell: one entry of the shifting cell chain
// Holds one value; on each op it keeps it, takes a neighbor's value,
// takes the inserted value, or wraps the head value in at the tail.
// ----------------------------------------------------------------------------
module clss_cell #(
	parameter int IDX = 0
) (
	input  logic                              clk,
	input  clss_pkg::cell_ctl_t               ctl,
	input  logic [clss_pkg::DATA_W-1:0]       left,
	input  logic [clss_pkg::DATA_W-1:0]       right,
	input  logic [clss_pkg::DATA_W-1:0]       head,
	output logic [clss_pkg::DATA_W-1:0]       data
);

	localparam logic [clss_pkg::POS_W-1:0] MY_POS = clss_pkg::POS_W'(IDX);

	logic [clss_pkg::DATA_W-1:0] data_q;
	logic [clss_pkg::DATA_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (ctl.op)
			clss_pkg::CELL_INS: begin
				if (MY_POS == ctl.pos) begin
					data_d = ctl.value;
				end else if (MY_POS > ctl.pos) begin
					data_d = left;
				end
			end
			clss_pkg::CELL_DEL: begin
				if (MY_POS >= ctl.pos) begin
					data_d = right;
				end
			end
			clss_pkg::CELL_ROT: begin
				if (MY_POS == ctl.pos) begin
					data_d = head;
				end else if (MY_POS < ctl.pos) begin
					data_d = right;
				end
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule
